// ===== rtl/core/godq_pkg.sv =====
`default_nettype none
package godq_pkg;

  localparam int COORD_W = 6;
  localparam int DIST_W  = 7;
  localparam int MAX_DIM = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] HEAD_NORTH = 2'd0;
  localparam logic [1:0] HEAD_WEST  = 2'd1;
  localparam logic [1:0] HEAD_SOUTH = 2'd2;
  localparam logic [1:0] HEAD_EAST  = 2'd3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [MAX_DIM-1:0] map_word_t;

  typedef struct packed {
    logic       operation;
    coord_t     cell_x;
    coord_t     cell_y;
    logic       blocked;
    logic [1:0] heading;
  } in_item_t;

  typedef struct packed {
    dist_t ahead_dist;
    dist_t behind_dist;
    dist_t left_dist;
    dist_t right_dist;
    dist_t nearest_dist;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FINISH
  } godq_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic write_back;
    logic finish;
  } godq_cmd_t;

  typedef struct packed {
    logic wr_item;
    logic in_grid;
  } godq_stat_t;

  // nearest set bit at or above pos, as an offset from pos
  function automatic dist_t scan_up(map_word_t w, coord_t pos, dist_t dflt);
    dist_t d;
    d = dflt;
    for (int k = MAX_DIM - 1; k >= 0; k--) begin
      if (w[k] && (DIST_W'(k) >= {1'b0, pos})) begin
        d = DIST_W'(k) - {1'b0, pos};
      end
    end
    return d;
  endfunction

  // nearest set bit strictly below pos, as an offset from pos
  function automatic dist_t scan_down(map_word_t w, coord_t pos, dist_t dflt);
    dist_t d;
    d = dflt;
    for (int k = 0; k < MAX_DIM; k++) begin
      if (w[k] && (DIST_W'(k) < {1'b0, pos})) begin
        d = {1'b0, pos} - DIST_W'(k);
      end
    end
    return d;
  endfunction

  function automatic dist_t min2(dist_t a, dist_t b);
    return (a < b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/godq_ram.sv =====
`default_nettype none
module godq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/godq_ctrl.sv =====
`default_nettype none
module godq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire godq_pkg::godq_stat_t stat,
  output logic                      busy,
  output godq_pkg::godq_cmd_t       cmd
);

  godq_pkg::godq_state_t state_r;
  godq_pkg::godq_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      godq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = godq_pkg::ST_READ;
        end
      end
      godq_pkg::ST_READ:   state_nxt = godq_pkg::ST_SCAN;
      godq_pkg::ST_SCAN:   state_nxt = godq_pkg::ST_FINISH;
      godq_pkg::ST_FINISH: state_nxt = godq_pkg::ST_IDLE;
      default:             state_nxt = godq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy           = 1'b1;
    cmd            = '0;
    case (state_r)
      godq_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      godq_pkg::ST_READ: begin
      end
      godq_pkg::ST_SCAN: begin
        cmd.scan       = 1'b1;
        cmd.write_back = stat.wr_item && stat.in_grid;
      end
      godq_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= godq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/godq_dp.sv =====
`default_nettype none
module godq_dp #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire godq_pkg::in_item_t  in_item,
  input  wire godq_pkg::godq_cmd_t cmd,
  output godq_pkg::godq_stat_t     stat,
  output logic                     out_valid,
  output godq_pkg::out_item_t      out_item
);

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);

  godq_pkg::in_item_t  item_r;
  godq_pkg::dist_t     dn_r, ds_r, de_r, dw_r;
  godq_pkg::out_item_t out_item_r;
  logic                out_valid_r;
  logic [GRID_HEIGHT-1:0] row_valid_r;
  logic [GRID_WIDTH-1:0]  col_valid_r;

  logic [XW-1:0] xi;
  logic [YW-1:0] yi;
  logic [GRID_WIDTH-1:0]  row_rdata, row_word, row_wdata;
  logic [GRID_HEIGHT-1:0] col_rdata, col_word, col_wdata;
  godq_pkg::map_word_t    row_ext, col_ext;
  godq_pkg::dist_t        a_d, b_d, l_d, r_d;
  godq_pkg::out_item_t    result;

  assign xi = item_r.cell_x[XW-1:0];
  assign yi = item_r.cell_y[YW-1:0];

  assign stat.wr_item = (item_r.operation == godq_pkg::OP_WRITE);
  assign stat.in_grid = ({1'b0, item_r.cell_x} < godq_pkg::DIST_W'(GRID_WIDTH)) &&
                        ({1'b0, item_r.cell_y} < godq_pkg::DIST_W'(GRID_HEIGHT));

  // row memory: one word per row, bit i is column i
  godq_ram #(.WIDTH(GRID_WIDTH), .DEPTH(GRID_HEIGHT)) u_row_ram (
    .clk   (clk),
    .we    (cmd.write_back),
    .waddr (yi),
    .wdata (row_wdata),
    .raddr (yi),
    .rdata (row_rdata)
  );

  // column memory: one word per column, bit j is row j
  godq_ram #(.WIDTH(GRID_HEIGHT), .DEPTH(GRID_WIDTH)) u_col_ram (
    .clk   (clk),
    .we    (cmd.write_back),
    .waddr (xi),
    .wdata (col_wdata),
    .raddr (xi),
    .rdata (col_rdata)
  );

  assign row_word = row_valid_r[yi] ? row_rdata : '0;
  assign col_word = col_valid_r[xi] ? col_rdata : '0;
  assign row_ext  = godq_pkg::map_word_t'(row_word);
  assign col_ext  = godq_pkg::map_word_t'(col_word);

  always_comb begin
    row_wdata     = row_word;
    row_wdata[xi] = item_r.blocked;
    col_wdata     = col_word;
    col_wdata[yi] = item_r.blocked;
  end

  always_comb begin
    case (item_r.heading)
      godq_pkg::HEAD_NORTH: begin
        a_d = dn_r; b_d = ds_r; l_d = de_r; r_d = dw_r;
      end
      godq_pkg::HEAD_WEST: begin
        a_d = dw_r; b_d = de_r; l_d = dn_r; r_d = ds_r;
      end
      godq_pkg::HEAD_SOUTH: begin
        a_d = ds_r; b_d = dn_r; l_d = dw_r; r_d = de_r;
      end
      default: begin
        a_d = de_r; b_d = dw_r; l_d = ds_r; r_d = dn_r;
      end
    endcase
    result.ahead_dist   = a_d;
    result.behind_dist  = b_d;
    result.left_dist    = l_d;
    result.right_dist   = r_d;
    result.nearest_dist = godq_pkg::min2(godq_pkg::min2(a_d, b_d),
                                         godq_pkg::min2(l_d, r_d));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.scan) begin
      dn_r <= godq_pkg::scan_up(col_ext, item_r.cell_y,
                godq_pkg::DIST_W'(GRID_HEIGHT) - {1'b0, item_r.cell_y});
      ds_r <= godq_pkg::scan_down(col_ext, item_r.cell_y, {1'b0, item_r.cell_y});
      dw_r <= godq_pkg::scan_up(row_ext, item_r.cell_x,
                godq_pkg::DIST_W'(GRID_WIDTH) - {1'b0, item_r.cell_x});
      de_r <= godq_pkg::scan_down(row_ext, item_r.cell_x, {1'b0, item_r.cell_x});
    end
    if (cmd.finish) begin
      out_item_r <= (!stat.wr_item && stat.in_grid) ? result : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
      col_valid_r <= '0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.write_back) begin
        row_valid_r[yi] <= 1'b1;
        col_valid_r[xi] <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ===== rtl/core/grid_obstacle_distance_query.sv =====
`default_nettype none
// Grid obstacle distance query. Holds a GRID_WIDTH x GRID_HEIGHT obstacle map (all free
// after reset) as a row memory and a column memory. Assert start with an item while busy
// is low: a write item sets or clears one cell, a query item returns the distances to
// the nearest obstacle or map edge in four directions, rotated by heading, and their
// minimum. Every item, write or query, yields exactly one result: out_valid is high for
// a single cycle once the registered memory read, the scan of the row and column words
// and the registered rotation and minimum are done, and the receiver cannot stall it,
// so capture out_item in that cycle. busy stays high after acceptance until out_valid
// rises, so a new item is not taken while one is in flight. Cells outside the grid
// are ignored and give an all-zero result.
module grid_obstacle_distance_query #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire godq_pkg::in_item_t in_item,
  output logic                    busy,
  output logic                    out_valid,
  output godq_pkg::out_item_t     out_item
);

  godq_pkg::godq_cmd_t  cmd;
  godq_pkg::godq_stat_t stat;

  godq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  godq_dp #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##4 out_valid)
    else $error("result transfer missing four cycles after acceptance");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 1530;

  class obstacle_ranger;
    bit                  occupied[godq_pkg::MAX_DIM][godq_pkg::MAX_DIM];
    godq_pkg::out_item_t pending_ranges[$];
    int                  errors;
    int                  results_seen;

    task report_mismatch(string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      errors++;
    endtask

    function godq_pkg::out_item_t range_for(godq_pkg::in_item_t it);
      godq_pkg::out_item_t r;
      godq_pkg::dist_t     dn, ds, de, dw;
      int                  x, y;
      r = '0;
      x = it.cell_x;
      y = it.cell_y;
      if (it.operation == godq_pkg::OP_WRITE) begin
        occupied[x][y] = it.blocked;
        return r;
      end
      dn = godq_pkg::dist_t'(godq_pkg::MAX_DIM - y);
      ds = godq_pkg::dist_t'(y);
      de = godq_pkg::dist_t'(x);
      dw = godq_pkg::dist_t'(godq_pkg::MAX_DIM - x);
      for (int k = godq_pkg::MAX_DIM - 1; k >= y; k--) begin
        if (occupied[x][k]) dn = godq_pkg::dist_t'(k - y);
      end
      for (int k = 0; k < y; k++) begin
        if (occupied[x][k]) ds = godq_pkg::dist_t'(y - k);
      end
      for (int k = 0; k < x; k++) begin
        if (occupied[k][y]) de = godq_pkg::dist_t'(x - k);
      end
      for (int k = godq_pkg::MAX_DIM - 1; k >= x; k--) begin
        if (occupied[k][y]) dw = godq_pkg::dist_t'(k - x);
      end
      case (it.heading)
        godq_pkg::HEAD_NORTH: r = '{dn, ds, de, dw, '0};
        godq_pkg::HEAD_WEST:  r = '{dw, de, dn, ds, '0};
        godq_pkg::HEAD_SOUTH: r = '{ds, dn, dw, de, '0};
        default:              r = '{de, dw, ds, dn, '0};
      endcase
      r.nearest_dist = dn;
      if (ds < r.nearest_dist) r.nearest_dist = ds;
      if (de < r.nearest_dist) r.nearest_dist = de;
      if (dw < r.nearest_dist) r.nearest_dist = dw;
      return r;
    endfunction

    function void take_item(godq_pkg::in_item_t it);
      pending_ranges.push_back(range_for(it));
    endfunction

    task compare_field(string name, godq_pkg::dist_t got, godq_pkg::dist_t want);
      if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task match_result(godq_pkg::out_item_t got);
      godq_pkg::out_item_t want;
      if (pending_ranges.size() == 0) begin
        report_mismatch("result with no transfer pending");
      end else begin
        want = pending_ranges.pop_front();
        compare_field("ahead_dist", got.ahead_dist, want.ahead_dist);
        compare_field("behind_dist", got.behind_dist, want.behind_dist);
        compare_field("left_dist", got.left_dist, want.left_dist);
        compare_field("right_dist", got.right_dist, want.right_dist);
        compare_field("nearest_dist", got.nearest_dist, want.nearest_dist);
      end
      results_seen++;
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  godq_pkg::in_item_t  in_item;
  logic                busy;
  logic                out_valid;
  godq_pkg::out_item_t out_item;

  obstacle_ranger   ranger = new();
  int               stall_count;
  godq_pkg::coord_t focus_x, focus_y;

  grid_obstacle_distance_query dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) ranger.match_result(out_item);
      if (start && !busy) ranger.take_item(in_item);
      if (out_valid || (start && !busy)) begin
        stall_count = 0;
      end else begin
        stall_count++;
        if (stall_count == WATCHDOG_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  function automatic godq_pkg::in_item_t cell_item(logic op, int x, int y, logic blk,
                                                   logic [1:0] hd);
    godq_pkg::in_item_t it;
    it.operation = op;
    it.cell_x    = godq_pkg::coord_t'(x);
    it.cell_y    = godq_pkg::coord_t'(y);
    it.blocked   = blk;
    it.heading   = hd;
    return it;
  endfunction

  function automatic godq_pkg::in_item_t roam_item();
    godq_pkg::in_item_t it;
    it.operation = ($urandom_range(99) < 45) ? godq_pkg::OP_QUERY : godq_pkg::OP_WRITE;
    if ($urandom_range(99) < 55) begin
      it.cell_x = godq_pkg::coord_t'(focus_x + $urandom_range(6) - 3);
      it.cell_y = godq_pkg::coord_t'(focus_y + $urandom_range(6) - 3);
    end else begin
      it.cell_x = godq_pkg::coord_t'($urandom);
      it.cell_y = godq_pkg::coord_t'($urandom);
    end
    it.blocked = ($urandom_range(99) < 65);
    it.heading = 2'($urandom);
    return it;
  endfunction

  // hold the item until the block takes it, then advance to the next falling edge
  task issue_item(godq_pkg::in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task run_phase(int count, int idle_pct);
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        focus_x = godq_pkg::coord_t'($urandom);
        focus_y = godq_pkg::coord_t'($urandom);
      end
      issue_item(roam_item());
      if ((i % 64) < 48 && $urandom_range(99) < idle_pct) pause_sender($urandom_range(1, 6));
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    issue_item(cell_item(godq_pkg::OP_QUERY, 0, 0, 1'b1, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_QUERY, 63, 63, 1'b0, godq_pkg::HEAD_EAST));
    issue_item(cell_item(godq_pkg::OP_WRITE, 5, 5, 1'b1, godq_pkg::HEAD_SOUTH));
    issue_item(cell_item(godq_pkg::OP_QUERY, 5, 5, 1'b0, godq_pkg::HEAD_WEST));
    issue_item(cell_item(godq_pkg::OP_WRITE, 5, 20, 1'b1, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_WRITE, 20, 5, 1'b1, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_WRITE, 5, 0, 1'b1, godq_pkg::HEAD_EAST));
    issue_item(cell_item(godq_pkg::OP_WRITE, 0, 5, 1'b1, godq_pkg::HEAD_WEST));
    issue_item(cell_item(godq_pkg::OP_QUERY, 5, 10, 1'b0, godq_pkg::HEAD_SOUTH));
    issue_item(cell_item(godq_pkg::OP_QUERY, 10, 5, 1'b1, godq_pkg::HEAD_EAST));
    issue_item(cell_item(godq_pkg::OP_QUERY, 5, 1, 1'b0, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_WRITE, 5, 5, 1'b0, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_QUERY, 5, 5, 1'b0, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_WRITE, 63, 0, 1'b1, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_WRITE, 63, 63, 1'b1, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_WRITE, 0, 63, 1'b1, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_QUERY, 63, 0, 1'b0, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_QUERY, 63, 0, 1'b0, godq_pkg::HEAD_WEST));
    issue_item(cell_item(godq_pkg::OP_QUERY, 63, 0, 1'b0, godq_pkg::HEAD_SOUTH));
    issue_item(cell_item(godq_pkg::OP_QUERY, 63, 0, 1'b0, godq_pkg::HEAD_EAST));
    issue_item(cell_item(godq_pkg::OP_QUERY, 0, 0, 1'b0, godq_pkg::HEAD_WEST));
    issue_item(cell_item(godq_pkg::OP_QUERY, 32, 63, 1'b0, godq_pkg::HEAD_SOUTH));
    issue_item(cell_item(godq_pkg::OP_WRITE, 0, 63, 1'b0, godq_pkg::HEAD_NORTH));
    issue_item(cell_item(godq_pkg::OP_QUERY, 0, 63, 1'b0, godq_pkg::HEAD_EAST));

    run_phase(RANDOM_ITEMS / 3, 23);
    run_phase(RANDOM_ITEMS / 3, 53);
    run_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0);
    start <= 1'b0;

    while (ranger.pending_ranges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ranger.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
